[sv/u8u16_pkg.sv]
// Shared types, constants and the Windows-1252 lookup for the UTF-8 to UTF-16 transcoder.
// Used by the decoder front, the job queue, the unit serialiser and the top level.
// No dependencies.
package u8u16_pkg;

  // Sequence length codes held while a multi-byte sequence is pending
  localparam logic [2:0] SeqIdle  = 3'd0;
  localparam logic [2:0] SeqTwo   = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour  = 3'd4;

  // Lead byte limits and second-byte limits
  localparam logic [7:0] LeadMin     = 8'hC2;
  localparam logic [7:0] LeadMax     = 8'hF4;
  localparam logic [7:0] LeadThree   = 8'hE0;
  localparam logic [7:0] LeadFour    = 8'hF0;
  localparam logic [7:0] LeadE0Min   = 8'hA0;
  localparam logic [7:0] LeadF0Min   = 8'h90;
  localparam logic [7:0] LeadF4Max   = 8'h8F;

  // Surrogate construction
  localparam logic [20:0] SuppBase   = 21'h10000;
  localparam logic [15:0] HighSurr   = 16'hD800;
  localparam logic [15:0] LowSurr    = 16'hDC00;

  // Maximum units one byte can cause, and queue depth
  localparam int unsigned MaxUnits   = 4;
  localparam int unsigned QueueDepth = 2;

  // One entry per byte 0x80-0x9F
  localparam logic [15:0] Win1252 [32] = '{
    16'h20ac, 16'h0081, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
    16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008d, 16'h017d, 16'h008f,
    16'h0090, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
    16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h009d, 16'h017e, 16'h0178
  };

  // Units caused by one input byte, in emission order
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [2:0]                count;
    logic                      eot;
  } job_t;

  // Queue fill status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Unit for a byte that stands alone
  function automatic logic [15:0] single_unit(input logic [7:0] b);
    logic [15:0] unit;
    if (b[7:5] == 3'b100) begin
      unit = Win1252[b[4:0]];
    end else begin
      unit = {8'h00, b};
    end
    return unit;
  endfunction

endpackage

[sv/u8u16_front.sv]
// Decoder front of the UTF-8 to UTF-16 transcoder: accepts bytes, tracks the
// pending sequence and builds one job of up to four code units per byte.
// Depends on u8u16_pkg.
module u8u16_front import u8u16_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_eot_i,
  input  queue_status_t status_i,
  output logic          push_o,
  output job_t          job_o
);

  logic [7:0]  lead_q, lead_d;
  logic [2:0]  len_q, len_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  held_q [2];
  logic [7:0]  held_d [2];
  logic        ok;
  logic        do_fresh;
  logic [2:0]  n;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic        accept;

  assign in_ready_o = !status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (job_o.count != 3'd0);

  // Classify the byte and collect the units it causes
  always_comb begin
    lead_d    = lead_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    held_d    = held_q;
    job_o     = '0;
    job_o.eot = in_eot_i;
    n         = 3'd0;
    do_fresh  = 1'b0;
    ok        = (in_byte_i[7:6] == 2'b10);
    cp        = '0;
    cp_off    = '0;

    if (len_q == SeqIdle) begin
      do_fresh = 1'b1;
    end else begin
      // Second-byte limits
      if (cnt_q == 2'd0) begin
        if (lead_q == LeadThree && in_byte_i < LeadE0Min) ok = 1'b0;
        if (lead_q == LeadFour && in_byte_i < LeadF0Min) ok = 1'b0;
        if (lead_q == LeadMax && in_byte_i > LeadF4Max) ok = 1'b0;
      end

      if (ok && (({1'b0, cnt_q} + 3'd2) == len_q)) begin
        // Complete sequence: assemble the code point
        case (len_q)
          SeqTwo:   cp = {10'd0, lead_q[4:0], in_byte_i[5:0]};
          SeqThree: cp = {5'd0, lead_q[3:0], held_q[0][5:0], in_byte_i[5:0]};
          default:  cp = {lead_q[2:0], held_q[0][5:0], held_q[1][5:0], in_byte_i[5:0]};
        endcase
        cp_off = cp - SuppBase;
        lead_d = '0;
        len_d  = SeqIdle;
        cnt_d  = '0;
        if (cp < SuppBase) begin
          job_o.units[n[1:0]] = cp[15:0];
          n = n + 3'd1;
        end else begin
          job_o.units[n[1:0]] = HighSurr | {6'd0, cp_off[19:10]};
          n = n + 3'd1;
          job_o.units[n[1:0]] = LowSurr | {6'd0, cp[9:0]};
          n = n + 3'd1;
        end
      end else if (ok && !in_eot_i && cnt_q < 2'd2) begin
        // Hold the continuation byte
        held_d[cnt_q[0]] = in_byte_i;
        cnt_d            = cnt_q + 2'd1;
      end else begin
        // Fall back: lead as itself, replay held bytes, then the byte afresh
        job_o.units[n[1:0]] = {8'h00, lead_q};
        n = n + 3'd1;
        if (cnt_q >= 2'd1) begin
          job_o.units[n[1:0]] = single_unit(held_q[0]);
          n = n + 3'd1;
        end
        if (cnt_q >= 2'd2) begin
          job_o.units[n[1:0]] = single_unit(held_q[1]);
          n = n + 3'd1;
        end
        lead_d   = '0;
        len_d    = SeqIdle;
        cnt_d    = '0;
        do_fresh = 1'b1;
      end
    end

    if (do_fresh) begin
      if (in_byte_i < LeadMin || in_byte_i > LeadMax || in_eot_i) begin
        job_o.units[n[1:0]] = single_unit(in_byte_i);
        n = n + 3'd1;
      end else begin
        // Open a new sequence
        lead_d = in_byte_i;
        cnt_d  = '0;
        if (in_byte_i < LeadThree) begin
          len_d = SeqTwo;
        end else if (in_byte_i < LeadFour) begin
          len_d = SeqThree;
        end else begin
          len_d = SeqFour;
        end
      end
    end

    if (in_eot_i) begin
      lead_d = '0;
      len_d  = SeqIdle;
      cnt_d  = '0;
    end

    job_o.count = n;
  end

  // Advance sequence state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      len_q  <= SeqIdle;
      cnt_q  <= '0;
    end else if (accept) begin
      lead_q <= lead_d;
      len_q  <= len_d;
      cnt_q  <= cnt_d;
    end
  end

  // Held continuation bytes carry no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

[sv/u8u16_queue.sv]
// Two-entry job queue between the decoder front and the unit serialiser.
// Depends on u8u16_pkg.
module u8u16_queue import u8u16_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  job_t          job_i,
  input  logic          pop_i,
  output job_t          job_o,
  output queue_status_t status_o
);

  job_t       mem_q [QueueDepth];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push;
  logic       do_pop;

  assign status_o.full  = (fill_q == 2'(QueueDepth));
  assign status_o.empty = (fill_q == 2'd0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = mem_q[rd_ptr_q];

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  // Store jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[sv/u8u16_back.sv]
// Unit serialiser of the UTF-8 to UTF-16 transcoder: takes jobs from the queue
// and presents their code units one per transaction on the output stream.
// Depends on u8u16_pkg.
module u8u16_back import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        job_i,
  input  logic        job_valid_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_unit_o,
  output logic        out_run_last_o,
  output logic        out_text_last_o
);

  job_t       cur_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       last_unit;
  logic       fire;
  logic       advance;

  assign last_unit       = (({1'b0, idx_q} + 3'd1) == cur_q.count);
  assign fire            = valid_q && out_ready_i;
  assign advance         = !valid_q || (fire && last_unit);
  assign pop_o           = advance && job_valid_i;

  assign out_valid_o     = valid_q;
  assign out_unit_o      = cur_q.units[idx_q];
  assign out_run_last_o  = last_unit;
  assign out_text_last_o = last_unit && cur_q.eot;

  // Step through units, load the next job after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (advance) begin
      valid_q <= job_valid_i;
      idx_q   <= '0;
    end else if (fire) begin
      idx_q   <= idx_q + 2'd1;
    end
  end

  // Hold the current job
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end
  end

endmodule

[sv/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16 transcoder: decoder front, job queue and
// unit serialiser. Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
//
// Usage:
//   Input stream: one UTF-8 byte per transaction in s_axis_tdata[7:0];
//   s_axis_tlast marks the final byte of a text and flushes any pending
//   sequence. Output stream: one UTF-16 code unit per transaction in
//   m_axis_tdata[15:0]; m_axis_tuser marks the last unit caused by an input
//   byte, m_axis_tlast the last unit of the whole text.
//   A byte causes zero to four units (surrogate pairs, or the replay of a
//   broken sequence). A job goes through a queue entry, then the current-job
//   register of the serialiser, before its first unit. Throughput is one byte
//   per cycle while each byte gives at most one unit and the receiver is ready;
//   a byte giving more units holds the output for each, set by that register.
//   A two-entry job queue decouples the sides: while the receiver stalls,
//   input is still taken until the queue fills, then s_axis_tready drops.
//   Reset clears the pending sequence, the queue and the output valid.
module utf8_to_utf16_transcoder import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tuser,   // [0] last_of_run
  output logic        m_axis_tlast    // text_done
);

  job_t          front_job;
  job_t          queue_job;
  logic          push;
  logic          pop;
  queue_status_t status;

  // Accept and classify bytes
  u8u16_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_eot_i   (s_axis_tlast),
    .status_i   (status),
    .push_o     (push),
    .job_o      (front_job)
  );

  // Buffer jobs
  u8u16_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (front_job),
    .pop_i    (pop),
    .job_o    (queue_job),
    .status_o (status)
  );

  // Emit units
  u8u16_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (queue_job),
    .job_valid_i     (!status.empty),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_unit_o      (m_axis_tdata),
    .out_run_last_o  (m_axis_tuser),
    .out_text_last_o (m_axis_tlast)
  );

  // End of text always falls on the last unit of a run
  a_text_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("text end flagged on a unit that does not end its run");

  // A run that is not finished keeps the output valid
  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid)
    else $error("output dropped in the middle of a run");

  // The front never pushes into a full queue
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.full |-> !push)
    else $error("job pushed into a full queue");

endmodule

[tb/utf8_to_utf16_transcoder_tb.sv]
// Self-checking testbench for utf8_to_utf16_transcoder: feeds UTF-8 bytes, predicts the
// UTF-16 code units and compares every output transaction against the prediction.
// Depends on u8u16_pkg and the transcoder RTL only.
module utf8_to_utf16_transcoder_tb import u8u16_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted code unit with its two marks
  typedef struct packed {
    logic [15:0] code;
    logic        run_end;
    logic        text_end;
  } utf16_unit_t;

  // One byte of text with its end-of-text flag
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } text_byte_t;

  // Predicts the code units of each accepted byte and matches them on the way out
  class utf16_unit_board;
    logic [15:0]  cp1252_hi [32];
    logic [7:0]   open_lead;
    logic [2:0]   open_len;
    logic [1:0]   cont_seen;
    logic [7:0]   cont_bytes [2];
    utf16_unit_t  step_units [$];
    utf16_unit_t  units_due [$];
    int unsigned  errors;
    int unsigned  bytes_taken;
    int unsigned  units_checked;
    int unsigned  pairs_seen;
    int unsigned  fallbacks_seen;

    function new();
      cp1252_hi = '{
        16'h20ac, 16'h0081, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
        16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008d, 16'h017d, 16'h008f,
        16'h0090, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
        16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h009d, 16'h017e, 16'h0178};
      open_lead = '0;
      open_len  = SeqIdle;
      cont_seen = '0;
      cont_bytes = '{8'h00, 8'h00};
      errors = 0;
      bytes_taken = 0;
      units_checked = 0;
      pairs_seen = 0;
      fallbacks_seen = 0;
    endfunction

    function void emit(logic [15:0] code);
      utf16_unit_t u;
      u.code = code;
      u.run_end = 1'b0;
      u.text_end = 1'b0;
      step_units.push_back(u);
    endfunction

    // Windows-1252 for 0x80-0x9F, the byte itself otherwise
    function logic [15:0] lone_unit(logic [7:0] b);
      if (b >= 8'h80 && b < 8'hA0) return cp1252_hi[b[4:0]];
      return {8'h00, b};
    endfunction

    function void close_seq();
      open_len  = SeqIdle;
      cont_seen = '0;
      open_lead = '0;
    endfunction

    function void start_byte(logic [7:0] b, logic eot);
      if (b < LeadMin || b > LeadMax || eot) begin
        emit(lone_unit(b));
        return;
      end
      open_lead = b;
      cont_seen = '0;
      open_len  = (b < LeadThree) ? SeqTwo : (b < LeadFour) ? SeqThree : SeqFour;
    endfunction

    function void extend_seq(logic [7:0] b, logic eot);
      logic [2:0]  pos;
      logic        ok;
      logic [20:0] cp;
      logic [20:0] off;
      pos = {1'b0, cont_seen} + 3'd1;
      ok  = (b[7:6] == 2'b10);
      if (ok && pos == 3'd1) begin
        if (open_lead == LeadThree && b < LeadE0Min) ok = 1'b0;
        if (open_lead == LeadFour && b < LeadF0Min) ok = 1'b0;
        if (open_lead == LeadMax && b > LeadF4Max) ok = 1'b0;
      end
      // Complete sequence: decode, split into a pair above the basic plane
      if (ok && pos + 3'd1 == open_len) begin
        case (open_len)
          SeqTwo:   cp = {10'd0, open_lead[4:0], b[5:0]};
          SeqThree: cp = {5'd0, open_lead[3:0], cont_bytes[0][5:0], b[5:0]};
          default:  cp = {open_lead[2:0], cont_bytes[0][5:0], cont_bytes[1][5:0], b[5:0]};
        endcase
        close_seq();
        if (cp < SuppBase) begin
          emit(cp[15:0]);
        end else begin
          off = cp - SuppBase;
          emit(HighSurr | {6'd0, off[19:10]});
          emit(LowSurr | {6'd0, cp[9:0]});
          pairs_seen++;
        end
        return;
      end
      // Hold a valid continuation byte
      if (ok && !eot && cont_seen < 2'd2) begin
        cont_bytes[cont_seen[0]] = b;
        cont_seen++;
        return;
      end
      // Broken or truncated: lead as itself, replay held bytes, restart on b
      fallbacks_seen++;
      emit({8'h00, open_lead});
      for (int k = 0; k < cont_seen; k++) emit(lone_unit(cont_bytes[k]));
      close_seq();
      start_byte(b, eot);
    endfunction

    function void take_byte(logic [7:0] b, logic eot);
      step_units.delete();
      bytes_taken++;
      if (open_len == SeqIdle) start_byte(b, eot);
      else extend_seq(b, eot);
      if (eot) close_seq();
      if (step_units.size() > 0) begin
        step_units[step_units.size()-1].run_end  = 1'b1;
        step_units[step_units.size()-1].text_end = eot;
      end
      foreach (step_units[i]) units_due.push_back(step_units[i]);
    endfunction

    function void match_unit(logic [15:0] code, logic run_end, logic text_end);
      utf16_unit_t want;
      if (units_due.size() == 0) begin
        $display("%0t: unexpected code unit, expected none, got %h/%b/%b",
                 $time, code, run_end, text_end);
        errors++;
        return;
      end
      want = units_due.pop_front();
      units_checked++;
      if (code !== want.code) begin
        $display("%0t: code_unit mismatch, expected %h, got %h", $time, want.code, code);
        errors++;
      end
      if (run_end !== want.run_end) begin
        $display("%0t: last_of_run mismatch, expected %b, got %b",
                 $time, want.run_end, run_end);
        errors++;
      end
      if (text_end !== want.text_end) begin
        $display("%0t: text_done mismatch, expected %b, got %b",
                 $time, want.text_end, text_end);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return units_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned     send_gap_pct = 0;
  int unsigned     recv_stall_pct = 0;
  utf16_unit_board board = new();
  text_byte_t      text_q [$];

  utf8_to_utf16_transcoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
    .s_axis_tlast  (s_axis_tlast),   // end_of_text
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] code_unit
    .m_axis_tuser  (m_axis_tuser),   // [0] last_of_run
    .m_axis_tlast  (m_axis_tlast)    // text_done
  );

  always #5 clk_i = ~clk_i;

  // Check each output transaction, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.match_unit(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Timeout with %0d code units still due", board.outstanding());
    $display("FAIL utf8_to_utf16_transcoder");
    $finish;
  end

  function automatic void queue_byte(logic [7:0] b, logic eot);
    text_byte_t t;
    t.data = b;
    t.eot  = eot;
    text_q.push_back(t);
  endfunction

  // Random end-of-text marks also truncate sequences now and then
  function automatic void queue_rand(logic [7:0] b);
    queue_byte(b, $urandom_range(0, 11) == 0);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // Mostly well-formed characters with random content, some noise and broken ones
  function automatic void build_text(int unsigned n_bytes);
    logic [7:0] lead;
    int unsigned start;
    start = text_q.size();
    while (text_q.size() - start < n_bytes) begin
      case ($urandom_range(0, 12))
        0, 1, 2: queue_rand(8'($urandom_range(0, 127)));
        3, 4: begin
          queue_rand(8'($urandom_range(8'hC2, 8'hDF)));
          queue_rand(cont_byte());
        end
        5, 6: begin
          lead = 8'($urandom_range(8'hE0, 8'hEF));
          queue_rand(lead);
          queue_rand(lead == LeadThree ? 8'($urandom_range(8'hA0, 8'hBF)) : cont_byte());
          queue_rand(cont_byte());
        end
        7: begin
          queue_rand(8'hED);
          queue_rand(8'($urandom_range(8'hA0, 8'hBF)));
          queue_rand(cont_byte());
        end
        8, 9: begin
          lead = 8'($urandom_range(8'hF0, 8'hF4));
          queue_rand(lead);
          if (lead == LeadFour) queue_rand(8'($urandom_range(8'h90, 8'hBF)));
          else if (lead == LeadMax) queue_rand(8'($urandom_range(8'h80, 8'h8F)));
          else queue_rand(cont_byte());
          queue_rand(cont_byte());
          queue_rand(cont_byte());
        end
        10: queue_rand(8'($urandom_range(8'h80, 8'hFF)));
        11: begin
          queue_rand(8'($urandom_range(8'hC2, 8'hF4)));
          repeat ($urandom_range(0, 2)) queue_rand(8'($urandom_range(0, 255)));
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       queue_rand(LeadThree);
            1:       queue_rand(LeadFour);
            default: queue_rand(LeadMax);
          endcase
          queue_rand(cont_byte());
          queue_rand(cont_byte());
          queue_rand(cont_byte());
        end
      endcase
    end
  endfunction

  // Offer one byte, with optional idle cycles first, and hold until taken
  task automatic send_byte(text_byte_t t);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t.data;
    s_axis_tlast  <= t.eot;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_byte(t.data, t.eot);
  endtask

  task automatic run_phase(int unsigned gap_pct, int unsigned stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    while (text_q.size() > 0) send_byte(text_q.pop_front());
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-byte classes, each sequence length, limits and fallbacks
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'hA0, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hC1, 1'b0);
    queue_byte(8'hC2, 1'b0); queue_byte(8'h80, 1'b0);
    // surrogate code point written as a three-byte sequence
    queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
    // highest code point, gives a surrogate pair
    queue_byte(8'hF4, 1'b0); queue_byte(8'h8F, 1'b0);
    queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
    // overlong second byte after E0
    queue_byte(8'hE0, 1'b0); queue_byte(8'h80, 1'b0);
    // non-continuation byte breaks a four-byte sequence after one held byte
    queue_byte(8'hF0, 1'b0); queue_byte(8'h90, 1'b0); queue_byte(8'h41, 1'b0);
    // truncation at end of text: three units from one byte
    queue_byte(8'hF1, 1'b0); queue_byte(8'h80, 1'b0); queue_byte(8'h80, 1'b1);
    // lead byte as the last of a text
    queue_byte(8'hF4, 1'b1);
    build_text(40);
    run_phase(0, 0);

    build_text(48);
    run_phase(53, 0);
    build_text(48);
    run_phase(0, 53);
    build_text(48);
    run_phase(27, 27);

    repeat (16) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d code units", board.bytes_taken, board.units_checked);
    $display("Seen %0d surrogate pairs and %0d broken or truncated sequences",
             board.pairs_seen, board.fallbacks_seen);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("PASS utf8_to_utf16_transcoder");
    end else begin
      $display("FAIL utf8_to_utf16_transcoder");
    end
    $finish;
  end

endmodule
